// ===== hw/rtl/sha1c_pkg.sv =====
// Shared types, constants and rotate functions for the SHA-1 compression engine.
`timescale 1ns / 1ps
`default_nettype none
package sha1c_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ChainWords = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_WORD  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam word_t H_INIT [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  // Control handed to the schedule chain each cycle
  typedef struct packed {
    logic shift;
    logic load;
  } sched_ctl_t;

  function automatic word_t rotl1(input word_t x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic word_t rotl5(input word_t x);
    return {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic word_t rotl30(input word_t x);
    return {x[1:0], x[WordW-1:2]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha1c_if.sv =====
// Request and result channel interfaces of the SHA-1 compression engine.
`timescale 1ns / 1ps
`default_nettype none
interface sha1c_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] msg_word;
  modport source (output valid, output func, output msg_word, input ready);
  modport sink (input valid, input func, input msg_word, output ready);
endinterface

interface sha1c_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sha1_compression.sv =====
// SHA-1 compression engine top level: request decode, round datapath and digest readout.
// Start and message-word requests are taken while idle; the sixteenth word of a block
// then runs 80 rounds, one per cycle, followed by the chaining add in the S_FIN state.
// No new request is taken until the chaining add is done and the engine is idle again.
// A read request emits five result words, one per cycle while the sink is ready.
// Synchronous active-low reset loads the initial chaining value and clears the word count.
`timescale 1ns / 1ps
`default_nettype none
module sha1_compression
  import sha1c_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1c_in_if.sink    in_ch,
  sha1c_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_FIN, S_READ} state_t;

  state_t      state_r;
  logic [3:0]  cnt_r;
  logic [6:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        out_valid_r;
  word_t       chain_r [ChainWords];
  word_t       a_r, b_r, c_r, d_r, e_r;

  logic        in_fire;
  logic        out_fire;
  func_t       func;
  word_t       wt;
  word_t       f;
  word_t       k;
  word_t       tmp;
  sched_ctl_t  sctl;

  assign func      = func_t'(in_ch.func);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire   = in_ch.valid & in_ch.ready;
  assign out_fire  = out_valid_r & out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = chain_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last        = (idx_r == 3'(ChainWords - 1));

  assign sctl.load  = (state_r == S_IDLE);
  assign sctl.shift = (in_fire && func == FUNC_WORD) || (state_r == S_COMP);

  sha1c_sched u_sched (
    .clk      (clk),
    .ctl      (sctl),
    .msg_word (in_ch.msg_word),
    .head     (wt)
  );

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_R0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K_R1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_R2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_R3;
    end
    tmp = rotl5(a_r) + f + e_r + k + wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ChainWords; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (func)
              FUNC_START: begin
                cnt_r <= '0;
                for (int i = 0; i < ChainWords; i++) begin
                  chain_r[i] <= H_INIT[i];
                end
              end
              FUNC_WORD: begin
                cnt_r <= cnt_r + 4'd1;
                if (cnt_r == 4'(BlockWords - 1)) begin
                  // Block complete: seed the working variables
                  a_r     <= chain_r[0];
                  b_r     <= chain_r[1];
                  c_r     <= chain_r[2];
                  d_r     <= chain_r[3];
                  e_r     <= chain_r[4];
                  rnd_r   <= '0;
                  state_r <= S_COMP;
                end
              end
              FUNC_READ: begin
                idx_r       <= '0;
                out_valid_r <= 1'b1;
                state_r     <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_COMP: begin
          a_r   <= tmp;
          b_r   <= a_r;
          c_r   <= rotl30(b_r);
          d_r   <= c_r;
          e_r   <= d_r;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(Rounds - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
          state_r    <= S_IDLE;
        end
        S_READ: begin
          if (out_fire) begin
            if (idx_r == 3'(ChainWords - 1)) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_no_req_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken while digest readout pending");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (rnd_r < 7'(Rounds)))
    else $error("round counter out of range");

  a_fin_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> ($past(state_r) == S_COMP && $past(rnd_r) == 7'(Rounds - 1)))
    else $error("chaining add without full 80 rounds");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (idx_r < 3'(ChainWords)))
    else $error("digest word index out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/sha1c_wcell.sv =====
// One cell of the message schedule chain: a word register that takes its neighbor's word.
`timescale 1ns / 1ps
`default_nettype none
module sha1c_wcell
  import sha1c_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift,
  input  wire word_t d,
  output word_t      q
);

  word_t word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sha1c_sched.sv =====
// Sixteen-cell message schedule chain with the rolling expansion feedback.
`timescale 1ns / 1ps
`default_nettype none
module sha1c_sched
  import sha1c_pkg::*;
(
  input  wire logic       clk,
  input  wire sched_ctl_t ctl,
  input  wire word_t      msg_word,
  output word_t           head
);

  word_t w [BlockWords];
  word_t fb;
  word_t push;

  // Cell 0 holds W[t]; the new W[t+16] enters at the tail
  assign fb   = rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);
  assign push = ctl.load ? msg_word : fb;
  assign head = w[0];

  for (genvar i = 0; i < BlockWords; i++) begin : g_cell
    word_t d;
    if (i == BlockWords - 1) begin : g_tail
      assign d = push;
    end else begin : g_mid
      assign d = w[i+1];
    end
    sha1c_wcell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (d),
      .q     (w[i])
    );
  end

endmodule
`default_nettype wire

// ===== test/tb_sha1_compression.sv =====
// Self-checking testbench for the SHA-1 compression engine with directed and random requests.
`timescale 1ns / 1ps
module tb_sha1_compression;
  import sha1c_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 150;

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  class digest_scoreboard;
    word_t        chain [ChainWords];
    word_t        sched [BlockWords];
    logic [3:0]   word_cnt;
    digest_beat_t digest_q [$];
    int           n_errors;
    int           n_checked;
    int           n_blocks;

    function new();
      for (int k = 0; k < ChainWords; k++) chain[k] = H_INIT[k];
      for (int k = 0; k < BlockWords; k++) sched[k] = '0;
      word_cnt  = '0;
      n_errors  = 0;
      n_checked = 0;
      n_blocks  = 0;
    endfunction

    function word_t rol(word_t x, int n);
      return (x << n) | (x >> (WordW - n));
    endfunction

    // Run the 80 rounds over the buffered block and fold into the chaining value
    function void compress();
      word_t w [BlockWords];
      word_t a, b, c, d, e, f, kc, wt, sum;
      int    stage;
      w = sched;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        stage = t / 20;
        if (t >= 16) begin
          wt = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
          w[t % 16] = wt;
        end else begin
          wt = w[t];
        end
        case (stage)
          0: begin
            f  = (b & c) | (~b & d);
            kc = K_R0;
          end
          1: begin
            f  = b ^ c ^ d;
            kc = K_R1;
          end
          2: begin
            f  = (b & c) | (b & d) | (c & d);
            kc = K_R2;
          end
          default: begin
            f  = b ^ c ^ d;
            kc = K_R3;
          end
        endcase
        sum = rol(a, 5) + f + e + kc + wt;
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
      n_blocks++;
    endfunction

    function void note_request(func_t f, word_t w);
      digest_beat_t beat;
      case (f)
        FUNC_START: begin
          for (int k = 0; k < ChainWords; k++) chain[k] = H_INIT[k];
          word_cnt = '0;
        end
        FUNC_WORD: begin
          sched[word_cnt] = w;
          word_cnt = word_cnt + 4'd1;
          if (word_cnt == 4'd0) compress();
        end
        FUNC_READ: begin
          for (int k = 0; k < ChainWords; k++) begin
            beat.word  = chain[k];
            beat.index = k[2:0];
            beat.last  = (k == ChainWords - 1);
            digest_q.push_back(beat);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(word_t w, logic [2:0] idx, logic l);
      digest_beat_t exp_beat;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b", $time, w, idx, l);
        n_errors++;
        return;
      end
      exp_beat = digest_q.pop_front();
      n_checked++;
      if (w !== exp_beat.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp_beat.word, w);
        n_errors++;
      end
      if (idx !== exp_beat.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp_beat.index, idx);
        n_errors++;
      end
      if (l !== exp_beat.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_beat.last, l);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   n_sent;
  int   idle_cycles = 0;

  digest_scoreboard sb;

  sha1c_in_if  in_ch ();
  sha1c_out_if out_ch ();

  sha1_compression u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(func_t f, word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.msg_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(f, w);
    n_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every pending digest word has come back
  task automatic drain_reads();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.digest_q.size() != 0);
  endtask

  task automatic send_words(int n);
    repeat (n) begin
      send_request(FUNC_WORD, rand_word());
      if ($urandom_range(19) == 0) send_request(FUNC_READ, rand_word());
    end
  endtask

  task automatic run_directed();
    send_request(FUNC_READ, '0);
    send_request(FUNC_NONE, 32'hFFFFFFFF);
    send_request(FUNC_READ, 32'hFFFFFFFF);
    send_request(FUNC_START, '0);
    // single padded block of "abc"
    send_request(FUNC_WORD, 32'h61626380);
    repeat (14) send_request(FUNC_WORD, '0);
    send_request(FUNC_WORD, 32'h00000018);
    send_request(FUNC_READ, '0);
    // continue without a start, read with a partial block buffered
    send_request(FUNC_WORD, 32'hFFFFFFFF);
    send_request(FUNC_READ, '0);
    send_request(FUNC_WORD, '0);
  endtask

  task automatic run_random(int upto);
    int pick;
    while (n_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // mostly whole messages; occasionally skip the start
        if ($urandom_range(9) != 0) send_request(FUNC_START, rand_word());
        repeat ($urandom_range(1, 3)) send_words(BlockWords);
        send_request(FUNC_READ, rand_word());
        if ($urandom_range(7) == 0) send_request(FUNC_READ, rand_word());
      end else if (pick < 85) begin
        send_request(func_t'($urandom_range(3)), rand_word());
      end else begin
        send_request(FUNC_START, rand_word());
        send_words($urandom_range(1, 15));
        send_request(FUNC_READ, rand_word());
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_NONE;
    in_ch.msg_word = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 28;
    recv_idle_pct  = 59;
    n_sent         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_random(95);

    drain_reads();
    send_idle_pct = 59;
    recv_idle_pct = 28;
    run_random(175);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(255);

    in_ch.valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d requests, compressed %0d blocks, checked %0d digest words",
             n_sent, sb.n_blocks, sb.n_checked);
    $display("Pacing: sender-heavy, receiver-heavy and back-to-back phases with one full drain");
    if (sb.n_errors == 0 && sb.digest_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
